// File: hw/rtl/pac_pkg.sv
// Shared types and constants for the pointer angle block.
// Holds the CORDIC turn table, the request kind codes and the pipeline control record.
// No dependencies.
package pac_pkg;

  localparam int CORDIC_STEPS = 30;
  localparam int VEC_FRAC     = 40;
  localparam int VEC_BITS     = 44;
  localparam int TURN_BITS    = 32;
  localparam int PIPE_LATENCY = CORDIC_STEPS + 3;

  localparam int CFG_INDEX_BITS = 2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_CENTER_X = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_CENTER_Y = 2'd1;

  typedef enum logic [3:0] {
    KIND_ZERO,
    KIND_UP,
    KIND_DOWN,
    KIND_RIGHT,
    KIND_LEFT,
    KIND_Q1,
    KIND_Q2,
    KIND_Q3,
    KIND_Q4
  } kind_t;

  typedef struct packed {
    logic  valid;
    kind_t kind;
  } ctrl_t;

  function automatic logic [TURN_BITS-1:0] turn_atan(input logic [4:0] step);
    logic [TURN_BITS-1:0] t;
    case (step)
      5'd0:    t = 32'd536870912;
      5'd1:    t = 32'd316933406;
      5'd2:    t = 32'd167458907;
      5'd3:    t = 32'd85004756;
      5'd4:    t = 32'd42667331;
      5'd5:    t = 32'd21354465;
      5'd6:    t = 32'd10679838;
      5'd7:    t = 32'd5340245;
      5'd8:    t = 32'd2670163;
      5'd9:    t = 32'd1335087;
      5'd10:   t = 32'd667544;
      5'd11:   t = 32'd333772;
      5'd12:   t = 32'd166886;
      5'd13:   t = 32'd83443;
      5'd14:   t = 32'd41722;
      5'd15:   t = 32'd20861;
      5'd16:   t = 32'd10430;
      5'd17:   t = 32'd5215;
      5'd18:   t = 32'd2608;
      5'd19:   t = 32'd1304;
      5'd20:   t = 32'd652;
      5'd21:   t = 32'd326;
      5'd22:   t = 32'd163;
      5'd23:   t = 32'd81;
      5'd24:   t = 32'd41;
      5'd25:   t = 32'd20;
      5'd26:   t = 32'd10;
      5'd27:   t = 32'd5;
      5'd28:   t = 32'd3;
      5'd29:   t = 32'd1;
      default: t = 32'd0;
    endcase
    return t;
  endfunction

endpackage

// File: hw/rtl/pac_prep.sv
// Front end: subtracts the center, then takes magnitudes and classifies the request.
// Two register stages. Depends on pac_pkg.
module pac_prep #(
  parameter int COORD_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  input  logic signed [COORD_BITS-1:0]        pointer_x,
  input  logic signed [COORD_BITS-1:0]        pointer_y,
  input  logic        [COORD_BITS-2:0]        center_x,
  input  logic        [COORD_BITS-2:0]        center_y,
  output pac_pkg::ctrl_t                      ctrl,
  output logic signed [pac_pkg::VEC_BITS-1:0] x,
  output logic signed [pac_pkg::VEC_BITS-1:0] y
);

  localparam int VB        = pac_pkg::VEC_BITS;
  localparam int VEC_SHIFT = pac_pkg::VEC_FRAC - COORD_BITS;

  logic                         diff_valid;
  logic signed [COORD_BITS:0]   dx;
  logic signed [COORD_BITS:0]   dy;
  logic signed [COORD_BITS:0]   dx_c;
  logic signed [COORD_BITS:0]   dy_c;
  logic        [COORD_BITS:0]   dx_neg;
  logic        [COORD_BITS:0]   dy_neg;
  logic        [COORD_BITS-1:0] ax;
  logic        [COORD_BITS-1:0] ay;
  logic                         dx_zero;
  logic                         dy_zero;
  pac_pkg::kind_t               kind_c;

  assign dx_c = {pointer_x[COORD_BITS-1], pointer_x} - $signed({2'b00, center_x});
  assign dy_c = {pointer_y[COORD_BITS-1], pointer_y} - $signed({2'b00, center_y});

  always_ff @(posedge clk) begin
    if (rst) begin
      diff_valid <= 1'b0;
    end else begin
      diff_valid <= in_valid;
    end
    dx <= dx_c;
    dy <= dy_c;
  end

  assign dx_neg  = -dx;
  assign dy_neg  = -dy;
  assign ax      = dx[COORD_BITS] ? dx_neg[COORD_BITS-1:0] : dx[COORD_BITS-1:0];
  assign ay      = dy[COORD_BITS] ? dy_neg[COORD_BITS-1:0] : dy[COORD_BITS-1:0];
  assign dx_zero = (dx == '0);
  assign dy_zero = (dy == '0);

  always_comb begin
    if (dx_zero && dy_zero) begin
      kind_c = pac_pkg::KIND_ZERO;
    end else if (dx_zero) begin
      kind_c = dy[COORD_BITS] ? pac_pkg::KIND_DOWN : pac_pkg::KIND_UP;
    end else if (dy_zero) begin
      kind_c = dx[COORD_BITS] ? pac_pkg::KIND_LEFT : pac_pkg::KIND_RIGHT;
    end else if (!dx[COORD_BITS] && !dy[COORD_BITS]) begin
      kind_c = pac_pkg::KIND_Q1;
    end else if (dx[COORD_BITS] && !dy[COORD_BITS]) begin
      kind_c = pac_pkg::KIND_Q2;
    end else if (dx[COORD_BITS]) begin
      kind_c = pac_pkg::KIND_Q3;
    end else begin
      kind_c = pac_pkg::KIND_Q4;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl.valid <= 1'b0;
    end else begin
      ctrl.valid <= diff_valid;
    end
    ctrl.kind <= kind_c;
    x         <= $signed(VB'(ax) << VEC_SHIFT);
    y         <= $signed(VB'(ay) << VEC_SHIFT);
  end

endmodule

// File: hw/rtl/pac_stage.sv
// One CORDIC vectoring step with its output register.
// Step index picks the shift and the turn table entry. Depends on pac_pkg.
module pac_stage #(
  parameter int STEP = 0
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  pac_pkg::ctrl_t                       ctrl_in,
  input  logic signed [pac_pkg::VEC_BITS-1:0]  x_in,
  input  logic signed [pac_pkg::VEC_BITS-1:0]  y_in,
  input  logic        [pac_pkg::TURN_BITS-1:0] z_in,
  output pac_pkg::ctrl_t                       ctrl_out,
  output logic signed [pac_pkg::VEC_BITS-1:0]  x_out,
  output logic signed [pac_pkg::VEC_BITS-1:0]  y_out,
  output logic        [pac_pkg::TURN_BITS-1:0] z_out
);

  localparam logic [pac_pkg::TURN_BITS-1:0] ATAN = pac_pkg::turn_atan(5'(STEP));

  logic signed [pac_pkg::VEC_BITS-1:0] xs;
  logic signed [pac_pkg::VEC_BITS-1:0] ys;

  assign xs = x_in >>> STEP;
  assign ys = y_in >>> STEP;

  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl_out.valid <= 1'b0;
    end else begin
      ctrl_out.valid <= ctrl_in.valid;
    end
    ctrl_out.kind <= ctrl_in.kind;
    if (!y_in[pac_pkg::VEC_BITS-1]) begin
      x_out <= x_in + ys;
      y_out <= y_in - xs;
      z_out <= z_in + ATAN;
    end else begin
      x_out <= x_in - ys;
      y_out <= y_in + xs;
      z_out <= z_in - ATAN;
    end
  end

endmodule

// File: hw/rtl/pac_finish.sv
// Back end: restores the quadrant, rounds the turn to the output width, registers the result.
// Handles the axis and zero cases exactly. Depends on pac_pkg.
module pac_finish #(
  parameter int ANGLE_BITS = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  pac_pkg::ctrl_t                 ctrl,
  input  logic [pac_pkg::TURN_BITS-1:0]  z,
  output logic                           done,
  output logic [ANGLE_BITS-1:0]          angle
);

  localparam int TB = pac_pkg::TURN_BITS;
  localparam logic [TB-1:0] HALF_TURN = {1'b1, {(TB-1){1'b0}}};

  logic [TB-1:0]         zq;
  logic [TB:0]           rounded;
  logic [ANGLE_BITS-1:0] angle_c;

  always_comb begin
    case (ctrl.kind)
      pac_pkg::KIND_Q2: zq = HALF_TURN - z;
      pac_pkg::KIND_Q3: zq = HALF_TURN + z;
      pac_pkg::KIND_Q4: zq = '0 - z;
      default:          zq = z;
    endcase
  end

  assign rounded = {1'b0, zq} + ((TB+1)'(1) << (TB - 1 - ANGLE_BITS));

  always_comb begin
    case (ctrl.kind)
      pac_pkg::KIND_ZERO,
      pac_pkg::KIND_RIGHT: angle_c = '0;
      pac_pkg::KIND_UP:    angle_c = ANGLE_BITS'(1) << (ANGLE_BITS - 2);
      pac_pkg::KIND_DOWN:  angle_c = ANGLE_BITS'(3) << (ANGLE_BITS - 2);
      pac_pkg::KIND_LEFT:  angle_c = ANGLE_BITS'(1) << (ANGLE_BITS - 1);
      default:             angle_c = rounded[TB-1 -: ANGLE_BITS];
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= ctrl.valid;
    end
    angle <= angle_c;
  end

endmodule

// File: hw/rtl/point_angle_about_center.sv
// Top level of the pointer angle block: center registers, front end, CORDIC chain, back end.
// Depends on pac_pkg, pac_prep, pac_stage and pac_finish.
//
//   channel  | handshake                     | payload
//   ---------+-------------------------------+----------------------------
//   request  | start, busy (accept: start&!busy) | pointer_x, pointer_y
//   result   | done (one-cycle strobe)       | angle
//   config   | cfg_valid, cfg_ready          | cfg_index, cfg_data
//
// One request per cycle while busy is low; each result follows its request through
// center subtract, classify, 30 CORDIC steps, quadrant restore and rounding.
// busy is high only during reset; reset empties the pipeline and clears the center.
// The pipeline never stalls: results leave on done whether or not anyone looks.
module point_angle_about_center #(
  parameter int ANGLE_BITS = 16,
  parameter int COORD_BITS = 16
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  start,
  output logic                                  busy,
  input  logic signed [COORD_BITS-1:0]          pointer_x,
  input  logic signed [COORD_BITS-1:0]          pointer_y,
  output logic                                  done,
  output logic        [ANGLE_BITS-1:0]          angle,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic        [pac_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic        [COORD_BITS-2:0]          cfg_data
);

  localparam int STEPS = pac_pkg::CORDIC_STEPS;

  logic [COORD_BITS-2:0] center_x;
  logic [COORD_BITS-2:0] center_y;

  pac_pkg::ctrl_t                       ctrl [STEPS+1];
  logic signed [pac_pkg::VEC_BITS-1:0]  x    [STEPS+1];
  logic signed [pac_pkg::VEC_BITS-1:0]  y    [STEPS+1];
  logic        [pac_pkg::TURN_BITS-1:0] z    [STEPS+1];

  assign busy      = rst;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      center_x <= '0;
      center_y <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        pac_pkg::REG_CENTER_X: center_x <= cfg_data;
        pac_pkg::REG_CENTER_Y: center_y <= cfg_data;
        default: ;
      endcase
    end
  end

  pac_prep #(
    .COORD_BITS(COORD_BITS)
  ) u_prep (
    .clk      (clk),
    .rst      (rst),
    .in_valid (start && !busy),
    .pointer_x(pointer_x),
    .pointer_y(pointer_y),
    .center_x (center_x),
    .center_y (center_y),
    .ctrl     (ctrl[0]),
    .x        (x[0]),
    .y        (y[0])
  );

  assign z[0] = '0;

  for (genvar i = 0; i < STEPS; i++) begin : g_step
    pac_stage #(
      .STEP(i)
    ) u_stage (
      .clk     (clk),
      .rst     (rst),
      .ctrl_in (ctrl[i]),
      .x_in    (x[i]),
      .y_in    (y[i]),
      .z_in    (z[i]),
      .ctrl_out(ctrl[i+1]),
      .x_out   (x[i+1]),
      .y_out   (y[i+1]),
      .z_out   (z[i+1])
    );
  end

  pac_finish #(
    .ANGLE_BITS(ANGLE_BITS)
  ) u_finish (
    .clk  (clk),
    .rst  (rst),
    .ctrl (ctrl[STEPS]),
    .z    (z[STEPS]),
    .done (done),
    .angle(angle)
  );

endmodule

// File: hw/rtl/pac_checker.sv
// Port-level checks for the pointer angle block, bound to the top level.
// Depends on pac_pkg for the pipeline latency.
module pac_checker (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic done
);

  localparam int LAT = pac_pkg::PIPE_LATENCY;

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##LAT done)
    else $error("request without result at fixed latency");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, LAT))
    else $error("result without matching request");

  a_reset_drains: assert property (@(posedge clk)
    rst |=> !done)
    else $error("result right after reset");

  a_busy_reset: assert property (@(posedge clk)
    !rst |-> !busy)
    else $error("busy outside reset");

endmodule

bind point_angle_about_center pac_checker u_pac_checker (
  .clk  (clk),
  .rst  (rst),
  .start(start),
  .busy (busy),
  .done (done)
);

// File: sim/tb_top.sv
// Self-checking testbench for point_angle_about_center.
// It drives random and directed pointer positions across several center settings and
// checks each angle against an in-bench CORDIC model. Depends on pac_pkg and the block RTL.
`timescale 1ns / 100ps

module tb_top;

  localparam int ANGLE_W = 16;
  localparam int COORD_W = 16;
  localparam int VEC_SHIFT = pac_pkg::VEC_FRAC - COORD_W;
  localparam logic [ANGLE_W-1:0] QUARTER_TURN = 16'h4000;
  localparam logic [ANGLE_W-1:0] HALF_TURN = 16'h8000;
  localparam logic [ANGLE_W-1:0] THREE_QUARTER_TURN = 16'hC000;
  localparam logic [pac_pkg::TURN_BITS-1:0] HALF_TURN_FINE = 32'h8000_0000;
  localparam logic [pac_pkg::TURN_BITS-1:0] ROUND_HALF = 32'h0000_8000;
  localparam logic [pac_pkg::CFG_INDEX_BITS-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [pac_pkg::CFG_INDEX_BITS-1:0] REG_SPARE_3 = 2'd3;
  localparam logic [COORD_W-2:0] CENTER_MAX = 15'h7fff;
  localparam int NUM_PHASES = 8;
  localparam int POINTS_PER_PHASE = 210;
  localparam int WATCHDOG_LIMIT = 2000;

  class angle_scoreboard;
    logic [COORD_W-2:0] center_x;
    logic [COORD_W-2:0] center_y;
    logic [ANGLE_W-1:0] expected_angles[$];
    bit [pac_pkg::TURN_BITS-1:0] atan_turns[pac_pkg::CORDIC_STEPS];
    int mismatches;

    function new();
      center_x = '0;
      center_y = '0;
      mismatches = 0;
      atan_turns = '{
        536870912, 316933406, 167458907, 85004756, 42667331,
        21354465, 10679838, 5340245, 2670163, 1335087,
        667544, 333772, 166886, 83443, 41722,
        20861, 10430, 5215, 2608, 1304,
        652, 326, 163, 81, 41,
        20, 10, 5, 3, 1};
    endfunction

    function void write_center(logic [pac_pkg::CFG_INDEX_BITS-1:0] index,
                               logic [COORD_W-2:0] data);
      case (index)
        pac_pkg::REG_CENTER_X: center_x = data;
        pac_pkg::REG_CENTER_Y: center_y = data;
        default: ;
      endcase
    endfunction

    function logic [ANGLE_W-1:0] predict_angle(logic [COORD_W-1:0] px, logic [COORD_W-1:0] py);
      logic signed [COORD_W+1:0] dx;
      logic signed [COORD_W+1:0] dy;
      logic [COORD_W+1:0] ax;
      logic [COORD_W+1:0] ay;
      logic signed [63:0] vx;
      logic signed [63:0] vy;
      logic signed [63:0] sx;
      logic signed [63:0] sy;
      logic [pac_pkg::TURN_BITS-1:0] z;
      logic [pac_pkg::TURN_BITS:0] rounded;
      dx = $signed({{2{px[COORD_W-1]}}, px}) - $signed({3'b000, center_x});
      dy = $signed({{2{py[COORD_W-1]}}, py}) - $signed({3'b000, center_y});
      if (dx == 0) begin
        if (dy > 0) return QUARTER_TURN;
        if (dy < 0) return THREE_QUARTER_TURN;
        return '0;
      end
      if (dy == 0) return (dx > 0) ? '0 : HALF_TURN;
      ax = (dx < 0) ? -dx : dx;
      ay = (dy < 0) ? -dy : dy;
      vx = {46'd0, ax};
      vy = {46'd0, ay};
      vx = vx <<< VEC_SHIFT;
      vy = vy <<< VEC_SHIFT;
      z = '0;
      for (int i = 0; i < pac_pkg::CORDIC_STEPS; i++) begin
        sx = vx >>> i;
        sy = vy >>> i;
        if (!vy[63]) begin
          vx = vx + sy;
          vy = vy - sx;
          z = z + atan_turns[i];
        end else begin
          vx = vx - sy;
          vy = vy + sx;
          z = z - atan_turns[i];
        end
      end
      if (dx > 0 && dy > 0) begin
      end else if (dx < 0 && dy > 0) begin
        z = HALF_TURN_FINE - z;
      end else if (dx < 0) begin
        z = HALF_TURN_FINE + z;
      end else begin
        z = 32'd0 - z;
      end
      rounded = {1'b0, z} + {1'b0, ROUND_HALF};
      return rounded[pac_pkg::TURN_BITS-1:pac_pkg::TURN_BITS-ANGLE_W];
    endfunction

    function void note_point(logic [COORD_W-1:0] px, logic [COORD_W-1:0] py);
      expected_angles.insert(expected_angles.size(), predict_angle(px, py));
    endfunction

    function void check_angle(logic [ANGLE_W-1:0] actual);
      logic [ANGLE_W-1:0] want;
      if (expected_angles.size() == 0) begin
        $error("angle: unexpected result %0d with no request outstanding", actual);
        mismatches++;
        return;
      end
      want = expected_angles.pop_front();
      if (actual !== want) begin
        $error("angle mismatch: expected %0d, actual %0d", want, actual);
        mismatches++;
      end
    endfunction

    function int pending();
      return expected_angles.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;
  logic start;
  logic busy;
  logic signed [COORD_W-1:0] pointer_x;
  logic signed [COORD_W-1:0] pointer_y;
  logic done;
  logic [ANGLE_W-1:0] angle;
  logic cfg_valid;
  logic cfg_ready;
  logic [pac_pkg::CFG_INDEX_BITS-1:0] cfg_index;
  logic [COORD_W-2:0] cfg_data;

  angle_scoreboard angles;
  int idle_cycles = 0;
  int burst_left = 0;

  point_angle_about_center #(
    .ANGLE_BITS(ANGLE_W),
    .COORD_BITS(COORD_W)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .pointer_x(pointer_x),
    .pointer_y(pointer_y),
    .done(done),
    .angle(angle),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst) begin
      idle_cycles <= 0;
    end else begin
      if (start && !busy) angles.note_point(pointer_x, pointer_y);
      if (done) angles.check_angle(angle);
      if (cfg_valid && cfg_ready) angles.write_center(cfg_index, cfg_data);
      if ((start && !busy) || done || (cfg_valid && cfg_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    while (idle_cycles < WATCHDOG_LIMIT) @(posedge clk);
    $display("CHECKS FAILED");
    $finish;
  end

  task automatic send_point(logic [COORD_W-1:0] px, logic [COORD_W-1:0] py);
    int gap;
    if (burst_left > 0) begin
      gap = 0;
      burst_left--;
    end else begin
      gap = $urandom_range(0, 19);
      if ($urandom_range(0, 15) == 0) burst_left = $urandom_range(10, 60);
    end
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    pointer_x <= px;
    pointer_y <= py;
    @(negedge clk);
    while (busy) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic write_reg(logic [pac_pkg::CFG_INDEX_BITS-1:0] index,
                           logic [COORD_W-2:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data <= data;
    @(negedge clk);
    while (!cfg_ready) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic drain_pipeline();
    start <= 1'b0;
    while (angles.pending() != 0) @(posedge clk);
    repeat (pac_pkg::PIPE_LATENCY + 4) @(posedge clk);
  endtask

  function automatic logic [COORD_W-1:0] spread(int bits);
    int mag;
    mag = $urandom_range(0, (1 << bits));
    return ($urandom_range(0, 1) == 1) ? COORD_W'(-mag) : COORD_W'(mag);
  endfunction

  task automatic send_random_point();
    int pick;
    logic [COORD_W-1:0] cx;
    logic [COORD_W-1:0] cy;
    logic [COORD_W-1:0] ox;
    logic [COORD_W-1:0] oy;
    cx = {1'b0, angles.center_x};
    cy = {1'b0, angles.center_y};
    pick = $urandom_range(0, 99);
    if (pick < 40) begin
      send_point(COORD_W'($urandom), COORD_W'($urandom));
    end else if (pick < 60) begin
      send_point(cx + spread(3), cy + spread(3));
    end else if (pick < 75) begin
      ox = spread($urandom_range(0, 15));
      oy = spread($urandom_range(0, 15));
      if ($urandom_range(0, 1) == 1) send_point(cx, cy + oy);
      else send_point(cx + ox, cy);
    end else begin
      send_point(cx + spread($urandom_range(0, 15)), cy + spread($urandom_range(0, 15)));
    end
  endtask

  initial begin
    logic [COORD_W-2:0] next_x;
    logic [COORD_W-2:0] next_y;
    angles = new();
    rst <= 1'b1;
    start <= 1'b0;
    pointer_x <= '0;
    pointer_y <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= pac_pkg::REG_CENTER_X;
    cfg_data <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    send_point(16'sd0, 16'sd0);
    send_point(16'sd0, 16'sd5);
    send_point(16'sd0, -16'sd5);
    send_point(16'sd7, 16'sd0);
    send_point(-16'sd7, 16'sd0);
    send_point(16'sd3, 16'sd4);
    send_point(-16'sd3, 16'sd4);
    send_point(-16'sd3, -16'sd4);
    send_point(16'sd3, -16'sd4);
    send_point(16'sd32767, -16'sd1);
    send_point(16'sd32767, 16'sd32767);
    send_point(-16'sd32768, -16'sd32768);
    send_point(-16'sd32768, 16'sd32767);
    send_point(16'sd32767, -16'sd32768);
    send_point(16'sd1, 16'sd1);
    send_point(-16'sd1, -16'sd1);
    send_point(16'sd32767, 16'sd1);
    send_point(16'sd1, 16'sd32767);
    send_point(-16'sd32768, 16'sd1);
    send_point(16'sd0, -16'sd32768);
    send_point(-16'sd32768, 16'sd0);
    send_point(16'sd0, 16'sd32767);
    send_point(16'sd32767, 16'sd0);
    drain_pipeline();

    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      case (phase)
        0: begin next_x = CENTER_MAX; next_y = CENTER_MAX; end
        1: begin next_x = '0; next_y = CENTER_MAX; end
        2: begin next_x = CENTER_MAX; next_y = '0; end
        3: begin next_x = 15'd16384; next_y = 15'd16384; end
        default: begin
          next_x = (COORD_W-1)'($urandom);
          next_y = (COORD_W-1)'($urandom);
        end
      endcase
      write_reg(pac_pkg::REG_CENTER_X, next_x);
      if (phase == 2 || phase == 5) begin
        write_reg(REG_SPARE_2, (COORD_W-1)'($urandom));
        write_reg(REG_SPARE_3, (COORD_W-1)'($urandom));
      end
      write_reg(pac_pkg::REG_CENTER_Y, next_y);
      cfg_valid <= 1'b0;
      @(posedge clk);

      send_point({1'b0, angles.center_x}, {1'b0, angles.center_y});
      send_point(16'sh7fff, 16'sh7fff);
      send_point(16'sh8000, 16'sh8000);
      send_point(16'sh8000, 16'sh7fff);
      send_point(16'sh7fff, 16'sh8000);
      for (int n = 0; n < POINTS_PER_PHASE; n++) send_random_point();
      drain_pipeline();
    end

    if (angles.pending() != 0)
      $error("angle: %0d expected results never arrived", angles.pending());
    if (angles.mismatches == 0 && angles.pending() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// File: filelist.f
hw/rtl/pac_pkg.sv
hw/rtl/pac_prep.sv
hw/rtl/pac_stage.sv
hw/rtl/pac_finish.sv
hw/rtl/point_angle_about_center.sv
hw/rtl/pac_checker.sv
sim/tb_top.sv
